// ===== rtl/core/bth_pkg.sv =====
package bth_pkg;

  // fit policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_NEXT  = 2'd1;
  localparam logic [1:0] POL_BEST  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // request kinds
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // register index of fit_policy
  localparam logic REG_FIT = 1'b0;

  // datapath command codes
  localparam int CMD_W = 5;
  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_NOP       = 5'd0;
  localparam cmd_t CMD_INIT0     = 5'd1;
  localparam cmd_t CMD_INIT1     = 5'd2;
  localparam cmd_t CMD_INIT2     = 5'd3;
  localparam cmd_t CMD_INIT3     = 5'd4;
  localparam cmd_t CMD_LOAD      = 5'd5;
  localparam cmd_t CMD_LOAD_RVR  = 5'd6;
  localparam cmd_t CMD_RD_P      = 5'd7;
  localparam cmd_t CMD_SCAN_EV   = 5'd8;
  localparam cmd_t CMD_PASS2     = 5'd9;
  localparam cmd_t CMD_TAKE_P    = 5'd10;
  localparam cmd_t CMD_TAKE_NEXT = 5'd11;
  localparam cmd_t CMD_TAKE_BEST = 5'd12;
  localparam cmd_t CMD_WR_SPL_H  = 5'd13;
  localparam cmd_t CMD_WR_SPL_F  = 5'd14;
  localparam cmd_t CMD_WR_HDR    = 5'd15;
  localparam cmd_t CMD_WR_FTR    = 5'd16;
  localparam cmd_t CMD_WALK_EV   = 5'd17;
  localparam cmd_t CMD_FREE_HDR  = 5'd18;
  localparam cmd_t CMD_FREE_NXT  = 5'd19;
  localparam cmd_t CMD_FREE_PRV  = 5'd20;
  localparam cmd_t CMD_WR_FREE_H = 5'd21;
  localparam cmd_t CMD_WR_FREE_F = 5'd22;
  localparam cmd_t CMD_RES_NOFIT = 5'd23;
  localparam cmd_t CMD_RES_BAD   = 5'd24;
  localparam cmd_t CMD_PUSH      = 5'd25;

  // datapath status toward the controller
  typedef struct packed {
    logic scan_ok;
    logic walk_ok;
    logic match_ok;
    logic addr_low;
    logic tag_zero;
    logic tag_used;
    logic fits;
    logic have_best;
    logic split;
  } dp_st_t;

endpackage

// ===== rtl/core/bth_ctrl.sv =====
module bth_ctrl import bth_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] fit_policy,
  input  logic       in_valid,
  input  logic       in_func,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_st_t     st,
  output cmd_t       cmd
);

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_ARD    = 5'd2;
  localparam logic [4:0] S_AEV    = 5'd3;
  localparam logic [4:0] S_AEND   = 5'd4;
  localparam logic [4:0] S_SPLIT  = 5'd5;
  localparam logic [4:0] S_SPLIT2 = 5'd6;
  localparam logic [4:0] S_WHDR   = 5'd7;
  localparam logic [4:0] S_WFTR   = 5'd8;
  localparam logic [4:0] S_FCHK   = 5'd9;
  localparam logic [4:0] S_FRD    = 5'd10;
  localparam logic [4:0] S_FEV    = 5'd11;
  localparam logic [4:0] S_CRD    = 5'd12;
  localparam logic [4:0] S_CEV    = 5'd13;
  localparam logic [4:0] S_NEV    = 5'd14;
  localparam logic [4:0] S_PEV    = 5'd15;
  localparam logic [4:0] S_WFH    = 5'd16;
  localparam logic [4:0] S_WFF    = 5'd17;
  localparam logic [4:0] S_RESP   = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pass2_r, pass2_nxt;
  logic       ovld_r, ovld_nxt;
  logic       is_next, is_best;

  assign is_next   = (fit_policy == POL_NEXT);
  assign is_best   = (fit_policy == POL_BEST);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovld_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass2_nxt = pass2_r;
    ovld_nxt  = ovld_r & out_stall;
    cmd       = CMD_NOP;
    case (state_r)
      S_INIT: begin
        case (cnt_r)
          2'd0: cmd = CMD_INIT0;
          2'd1: cmd = CMD_INIT1;
          2'd2: cmd = CMD_INIT2;
          default: cmd = CMD_INIT3;
        endcase
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          pass2_nxt = 1'b0;
          if (in_func == FUNC_ALLOC) begin
            cmd = is_next ? CMD_LOAD_RVR : CMD_LOAD;
            state_nxt = S_ARD;
          end else begin
            cmd = CMD_LOAD;
            state_nxt = S_FCHK;
          end
        end
      end
      S_ARD: begin
        if (st.scan_ok) begin
          cmd = CMD_RD_P;
          state_nxt = S_AEV;
        end else begin
          state_nxt = S_AEND;
        end
      end
      S_AEV: begin
        if (st.tag_zero) begin
          state_nxt = S_AEND;
        end else if (st.fits && !is_best) begin
          cmd = is_next ? CMD_TAKE_NEXT : CMD_TAKE_P;
          state_nxt = S_SPLIT;
        end else begin
          cmd = CMD_SCAN_EV;
          state_nxt = S_ARD;
        end
      end
      // end of one search pass
      S_AEND: begin
        if (is_next && !pass2_r) begin
          cmd = CMD_PASS2;
          pass2_nxt = 1'b1;
          state_nxt = S_ARD;
        end else if (is_best && st.have_best) begin
          cmd = CMD_TAKE_BEST;
          state_nxt = S_SPLIT;
        end else begin
          cmd = CMD_RES_NOFIT;
          state_nxt = S_RESP;
        end
      end
      S_SPLIT: begin
        if (st.split) begin
          cmd = CMD_WR_SPL_H;
          state_nxt = S_SPLIT2;
        end else begin
          state_nxt = S_WHDR;
        end
      end
      S_SPLIT2: begin
        cmd = CMD_WR_SPL_F;
        state_nxt = S_WHDR;
      end
      S_WHDR: begin
        cmd = CMD_WR_HDR;
        state_nxt = S_WFTR;
      end
      S_WFTR: begin
        cmd = CMD_WR_FTR;
        state_nxt = S_RESP;
      end
      S_FCHK: begin
        if (st.addr_low) begin
          cmd = CMD_RES_BAD;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        if (st.walk_ok) begin
          cmd = CMD_RD_P;
          state_nxt = S_FEV;
        end else begin
          state_nxt = S_CRD;
        end
      end
      S_FEV: begin
        if (st.tag_zero) begin
          state_nxt = S_CRD;
        end else begin
          cmd = CMD_WALK_EV;
          state_nxt = S_FRD;
        end
      end
      S_CRD: begin
        if (st.match_ok) begin
          cmd = CMD_RD_P;
          state_nxt = S_CEV;
        end else begin
          cmd = CMD_RES_BAD;
          state_nxt = S_RESP;
        end
      end
      S_CEV: begin
        if (!st.tag_used || st.tag_zero) begin
          cmd = CMD_RES_BAD;
          state_nxt = S_RESP;
        end else begin
          cmd = CMD_FREE_HDR;
          state_nxt = S_NEV;
        end
      end
      S_NEV: begin
        cmd = CMD_FREE_NXT;
        state_nxt = S_PEV;
      end
      S_PEV: begin
        cmd = CMD_FREE_PRV;
        state_nxt = S_WFH;
      end
      S_WFH: begin
        cmd = CMD_WR_FREE_H;
        state_nxt = S_WFF;
      end
      S_WFF: begin
        cmd = CMD_WR_FREE_F;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!ovld_r || !out_stall) begin
          cmd = CMD_PUSH;
          ovld_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= 2'd0;
      pass2_r <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pass2_r <= pass2_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

// ===== rtl/core/bth_dp.sv =====
module bth_dp import bth_pkg::*; #(
  parameter int HEAP_BYTES = 65536,
  parameter int MIN_BLOCK  = 32,
  parameter int WORD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [16:0] in_req_size,
  input  logic [15:0] in_free_addr,
  output dp_st_t      st,
  output logic [15:0] out_payload_addr,
  output logic [1:0]  out_status
);

  localparam int OFF_W = $clog2(HEAP_BYTES) + 1;
  localparam int TAG_W = OFF_W + 1;
  localparam int NW    = ((OFF_W > 17) ? OFF_W : 17) + 1;
  localparam int DEPTH = HEAP_BYTES / WORD_BYTES;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int HS_I  = ((WORD_BYTES + MIN_BLOCK - 1) / MIN_BLOCK) * MIN_BLOCK;
  localparam int HE_I  = ((HEAP_BYTES - WORD_BYTES) / MIN_BLOCK) * MIN_BLOCK;
  localparam logic [OFF_W-1:0] HS  = OFF_W'(HS_I);
  localparam logic [OFF_W-1:0] HE  = OFF_W'(HE_I);
  localparam logic [OFF_W-1:0] WB  = OFF_W'(WORD_BYTES);
  localparam logic [OFF_W-1:0] SZ0 = OFF_W'(HE_I - HS_I);
  localparam logic [NW-1:0]    PAD = NW'(2 * WORD_BYTES + MIN_BLOCK - 1);

  logic [TAG_W-1:0] mem [DEPTH];
  logic [TAG_W-1:0] rdata_r;

  logic [OFF_W-1:0] p_r, lim_r, target_r, best_r, bsz_r, blk_r, bsize_r;
  logic [OFF_W-1:0] hdr_r, size_r, rover_r;
  logic [NW-1:0]    need_r;
  logic             alow_r, have_r;
  logic [15:0]      res_addr_r;
  logic [1:0]       res_st_r;
  logic [15:0]      oaddr_r;
  logic [1:0]       ost_r;

  logic [OFF_W-1:0] s, n, rest, rd_off, wr_off, wr_size;
  logic [OFF_W-1:0] rd_q, wr_q;
  logic [NW-1:0]    need_c;
  logic             used, fits, better, rd_en, wr_en, wr_alloc;

  assign s      = rdata_r[TAG_W-1:1];
  assign used   = rdata_r[0];
  assign n      = need_r[OFF_W-1:0];
  assign rest   = bsize_r - n;
  assign fits   = !used && (NW'(s) >= need_r);
  assign better = !have_r || (s <= bsz_r);
  assign need_c = NW'(((NW'(in_req_size) + PAD) / MIN_BLOCK) * MIN_BLOCK);

  // status toward the controller
  always_comb begin
    st.scan_ok   = (p_r < lim_r) && (p_r < HE);
    st.walk_ok   = (p_r < HE) && (p_r < target_r);
    st.match_ok  = (p_r == target_r) && (p_r < HE);
    st.addr_low  = alow_r;
    st.tag_zero  = (s == '0);
    st.tag_used  = used;
    st.fits      = fits;
    st.have_best = have_r;
    st.split     = (n < bsize_r);
  end

  // memory port selection
  always_comb begin
    rd_en    = 1'b0;
    rd_off   = p_r;
    wr_en    = 1'b0;
    wr_off   = p_r;
    wr_size  = '0;
    wr_alloc = 1'b0;
    case (cmd)
      CMD_RD_P: rd_en = 1'b1;
      CMD_FREE_HDR: begin
        rd_en  = 1'b1;
        rd_off = p_r + s;
      end
      CMD_FREE_NXT: begin
        rd_en  = 1'b1;
        rd_off = p_r - WB;
      end
      CMD_INIT0: begin
        wr_en = 1'b1; wr_off = HS - WB; wr_alloc = 1'b1;
      end
      CMD_INIT1: begin
        wr_en = 1'b1; wr_off = HE; wr_alloc = 1'b1;
      end
      CMD_INIT2: begin
        wr_en = 1'b1; wr_off = HS; wr_size = SZ0;
      end
      CMD_INIT3: begin
        wr_en = 1'b1; wr_off = HE - WB; wr_size = SZ0;
      end
      CMD_WR_SPL_H: begin
        wr_en = 1'b1; wr_off = blk_r + n; wr_size = rest;
      end
      CMD_WR_SPL_F: begin
        wr_en = 1'b1; wr_off = blk_r + bsize_r - WB; wr_size = rest;
      end
      CMD_WR_HDR: begin
        wr_en = 1'b1; wr_off = blk_r; wr_size = n; wr_alloc = 1'b1;
      end
      CMD_WR_FTR: begin
        wr_en = 1'b1; wr_off = blk_r + n - WB; wr_size = n; wr_alloc = 1'b1;
      end
      CMD_WR_FREE_H: begin
        wr_en = 1'b1; wr_off = hdr_r; wr_size = size_r;
      end
      CMD_WR_FREE_F: begin
        wr_en = 1'b1; wr_off = hdr_r + size_r - WB; wr_size = size_r;
      end
      default: ;
    endcase
  end

  assign rd_q = OFF_W'(rd_off / WORD_BYTES);
  assign wr_q = OFF_W'(wr_off / WORD_BYTES);

  // tag store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_q[IDX_W-1:0]] <= {wr_size, wr_alloc};
    if (rd_en) rdata_r <= mem[rd_q[IDX_W-1:0]];
  end

  // next-fit rover
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rover_r <= HS;
    end else if (cmd == CMD_TAKE_NEXT) begin
      rover_r <= p_r;
    end else if (cmd == CMD_WR_FREE_F) begin
      if ((rover_r >= hdr_r) && (rover_r < hdr_r + size_r)) rover_r <= hdr_r;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD, CMD_LOAD_RVR: begin
        need_r   <= need_c;
        target_r <= OFF_W'(in_free_addr) - WB;
        alow_r   <= (OFF_W'(in_free_addr) < WB);
        p_r      <= (cmd == CMD_LOAD_RVR) ? rover_r : HS;
        lim_r    <= HE;
        have_r   <= 1'b0;
      end
      CMD_SCAN_EV: begin
        if (fits && better) begin
          best_r <= p_r;
          bsz_r  <= s;
          have_r <= 1'b1;
        end
        p_r <= p_r + s;
      end
      CMD_WALK_EV: p_r <= p_r + s;
      CMD_PASS2: begin
        p_r   <= HS;
        lim_r <= rover_r;
      end
      CMD_TAKE_P, CMD_TAKE_NEXT: begin
        blk_r   <= p_r;
        bsize_r <= s;
      end
      CMD_TAKE_BEST: begin
        blk_r   <= best_r;
        bsize_r <= bsz_r;
      end
      CMD_WR_FTR: begin
        res_addr_r <= 16'(blk_r + WB);
        res_st_r   <= ST_OK;
      end
      CMD_FREE_HDR: begin
        hdr_r  <= p_r;
        size_r <= s;
      end
      CMD_FREE_NXT: if (!used) size_r <= size_r + s;
      CMD_FREE_PRV: begin
        if (!used) begin
          hdr_r  <= p_r - s;
          size_r <= size_r + s;
        end
      end
      CMD_WR_FREE_F: begin
        res_addr_r <= 16'd0;
        res_st_r   <= ST_OK;
      end
      CMD_RES_NOFIT: begin
        res_addr_r <= 16'd0;
        res_st_r   <= ST_NOFIT;
      end
      CMD_RES_BAD: begin
        res_addr_r <= 16'd0;
        res_st_r   <= ST_BAD;
      end
      CMD_PUSH: begin
        oaddr_r <= res_addr_r;
        ost_r   <= res_st_r;
      end
      default: ;
    endcase
  end

  assign out_payload_addr = oaddr_r;
  assign out_status       = ost_r;

endmodule

// ===== rtl/core/boundary_tag_heap_allocator_top.sv =====
// Boundary-tag heap allocator.
// Input channel (in_valid/in_stall): one request word per item; in_func 0
// allocates in_req_size bytes, 1 releases the payload at in_free_addr.
// Output channel (out_valid/out_stall): one result word per request with
// out_payload_addr and out_status (ok, no fit, bad free).
// Configuration: APB write of fit_policy at address 0 (first, next, best).
// Requests are handled one at a time. An allocate reads and then
// evaluates the tag of each block walked in the implicit list; a free
// does the same for each block walked up to the target. The registered
// tag memory read sets the per-block cost.
// The result sits in an output register; while the receiver stalls it
// holds, and the block finishes the next request and waits to hand it over.
// After reset an init pass writes the sentinel tags and the
// single free block; in_stall stays high until it ends.
module boundary_tag_heap_allocator_top import bth_pkg::*; #(
  parameter int HEAP_BYTES = 65536,
  parameter int MIN_BLOCK  = 32,
  parameter int WORD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [16:0] in_req_size,
  input  logic [15:0] in_free_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_payload_addr,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] fit_r;
  dp_st_t     st;
  cmd_t       cmd;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r <= POL_FIRST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_FIT)) begin
      fit_r <= pwdata[1:0];
    end
  end
  assign prdata = (paddr[2] == REG_FIT) ? {30'd0, fit_r} : 32'd0;

  bth_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fit_policy(fit_r),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  bth_dp #(
    .HEAP_BYTES(HEAP_BYTES),
    .MIN_BLOCK (MIN_BLOCK),
    .WORD_BYTES(WORD_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_size     (in_req_size),
    .in_free_addr    (in_free_addr),
    .st              (st),
    .out_payload_addr(out_payload_addr),
    .out_status      (out_status)
  );

endmodule

// ===== rtl/core/bth_chk.sv =====
module bth_chk import bth_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_payload_addr,
  input logic [1:0]  out_status
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_addr) && $stable(out_status))
    else $error("stalled result changed");

  // failed requests return a zero offset
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_payload_addr == 16'd0)
    else $error("nonzero offset on failure");

  // no unused status code
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_NOFIT) || (out_status == ST_BAD))
    else $error("bad status code");

  // one request at a time: busy right after accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule

bind boundary_tag_heap_allocator_top bth_chk u_bth_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_payload_addr(out_payload_addr),
  .out_status      (out_status)
);
